// ===== sv/stpq_pkg.sv =====
`timescale 1ns / 1ps

package stpq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] prio;
    logic [KEY_W-1:0] size;
    logic [KEY_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic   insert_en;
    logic   pop_en;
    entry_t new_entry;
  } cell_ctrl_t;

  // True when entry a must stand in front of entry b.
  function automatic logic goes_before(input entry_t a, input entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = a.prio > b.prio;
    end else if (a.size != b.size) begin
      r = a.size < b.size;
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

endpackage

// ===== sv/stpq_cell.sv =====
`timescale 1ns / 1ps

module stpq_cell (
  input  logic                clk,
  input  stpq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  stpq_pkg::entry_t    prev_entry,
  input  logic                prev_takes_new,
  input  stpq_pkg::entry_t    next_entry,
  output stpq_pkg::entry_t    entry,
  output logic                takes_new
);

  // An empty cell always yields to a new word, so the first empty cell takes it.
  assign takes_new = !occupied || stpq_pkg::goes_before(ctrl.new_entry, entry);

  always_ff @(posedge clk) begin
    if (ctrl.insert_en && takes_new) begin
      entry <= prev_takes_new ? prev_entry : ctrl.new_entry;
    end else if (ctrl.pop_en) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== sv/sorted_task_priority_queue_top.sv =====
`timescale 1ns / 1ps

// Sorted task queue built as a row of DEPTH cells, front entry in cell zero.
// Input words arrive on task_valid/task_stall with opcode and the three keys;
// an insert places the task behind all entries that rank ahead of or equal to
// it, a pop removes the front entry. Key fields are ignored on a pop.
// Each accepted word produces exactly one result word on
// result_valid/result_stall carrying status, the popped entry (zero unless a
// pop succeeded) and the occupancy after the operation.
// Every cell compares its entry with the new task in parallel and shifts with
// its neighbor in the same cycle, so while task_stall is low one word is taken
// per clock and its result comes out of the output register in the next cycle.
// While a result waits under result_stall, task_stall is raised and no new
// word is taken; the pending result and the queue hold their values.
// Reset empties the queue and drops any pending result; no clearing pass
// is needed because cell contents are only ever read below the count.
module sorted_task_priority_queue_top #(
  parameter int DEPTH = stpq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          task_valid,
  output logic                          task_stall,
  input  logic                          opcode,
  input  logic [stpq_pkg::KEY_W-1:0]    task_priority,
  input  logic [stpq_pkg::KEY_W-1:0]    request_size,
  input  logic [stpq_pkg::KEY_W-1:0]    task_number,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [stpq_pkg::STATUS_W-1:0] status,
  output logic [stpq_pkg::KEY_W-1:0]    out_priority,
  output logic [stpq_pkg::KEY_W-1:0]    out_size,
  output logic [stpq_pkg::KEY_W-1:0]    out_task,
  output logic [stpq_pkg::OCC_W-1:0]    occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   accept;
  logic                   is_full;
  logic                   is_empty;
  logic [31:0]            count_ext;
  stpq_pkg::cell_ctrl_t   ctrl;
  stpq_pkg::entry_t       new_entry;
  stpq_pkg::entry_t       zero_entry;
  stpq_pkg::entry_t       cell_entry [DEPTH];
  logic                   cell_takes_new [DEPTH];

  assign task_stall = result_valid && result_stall;
  assign accept     = task_valid && !task_stall;
  assign is_full    = count == CW'(DEPTH);
  assign is_empty   = count == '0;

  assign new_entry.prio = task_priority;
  assign new_entry.size = request_size;
  assign new_entry.id   = task_number;
  assign zero_entry     = '0;

  assign ctrl.insert_en = accept && (opcode == stpq_pkg::OP_INSERT) && !is_full;
  assign ctrl.pop_en    = accept && (opcode == stpq_pkg::OP_POP) && !is_empty;
  assign ctrl.new_entry = new_entry;

  always_comb begin
    count_next = count;
    if (ctrl.insert_en) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop_en) begin
      count_next = count - CW'(1);
    end
  end

  assign count_ext = 32'(count_next);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stpq_cell u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .occupied       (CW'(i) < count),
      .prev_entry     ((i == 0) ? zero_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .prev_takes_new ((i == 0) ? 1'b0 : cell_takes_new[(i == 0) ? 0 : i - 1]),
      .next_entry     ((i == DEPTH - 1) ? zero_entry
                                        : cell_entry[(i == DEPTH - 1) ? i : i + 1]),
      .entry          (cell_entry[i]),
      .takes_new      (cell_takes_new[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= count_ext[stpq_pkg::OCC_W-1:0];
      if (opcode == stpq_pkg::OP_POP && !is_empty) begin
        status       <= stpq_pkg::ST_OK;
        out_priority <= cell_entry[0].prio;
        out_size     <= cell_entry[0].size;
        out_task     <= cell_entry[0].id;
      end else begin
        out_priority <= '0;
        out_size     <= '0;
        out_task     <= '0;
        if (opcode == stpq_pkg::OP_INSERT) begin
          status <= is_full ? stpq_pkg::ST_FULL : stpq_pkg::ST_OK;
        end else begin
          status <= stpq_pkg::ST_EMPTY;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_full_flag : assert property (@(posedge clk) disable iff (rst)
    accept && opcode == stpq_pkg::OP_INSERT && is_full |=>
      result_valid && status == stpq_pkg::ST_FULL && $stable(count))
    else $error("insert into full queue not flagged");

  a_empty_flag : assert property (@(posedge clk) disable iff (rst)
    accept && opcode == stpq_pkg::OP_POP && is_empty |=>
      result_valid && status == stpq_pkg::ST_EMPTY && out_task == '0)
    else $error("pop on empty queue not flagged");

  a_front_sorted : assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> !stpq_pkg::goes_before(cell_entry[1], cell_entry[0]))
    else $error("front entries out of order");
`endif

endmodule
